[hdl/hsk_pkg.sv]
// Shared types, constants and the character-to-keycode map for the six-key
// rollover report unit. Depends on nothing; used by every file in hdl.
package hsk_pkg;

	// Number of key slots in the held list, and fields in one report.
	localparam int KEY_SLOTS  = 6;
	localparam int OUT_FIELDS = 6;
	localparam int KEY_W      = 7;

	typedef logic [KEY_W-1:0] key_t;

	// Operation codes of an input word.
	localparam logic OP_PRESS   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// Characters and the keycodes they map to.
	localparam logic [7:0] CHAR_ONE    = 8'h31;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_COMMA  = 8'h2C;
	localparam logic [7:0] CHAR_ESCAPE = 8'hDF;

	localparam key_t KEY_NONE   = 7'h00;
	localparam key_t KEY_ONE    = 7'h1E;
	localparam key_t KEY_ZERO   = 7'h27;
	localparam key_t KEY_COMMA  = 7'h36;
	localparam key_t KEY_ESCAPE = 7'h29;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic valid;
		logic release_op;
		key_t key;
	} cmd_t;

	// Flags rippled from one cell to the next.
	typedef struct packed {
		logic blocked;  // an earlier slot already holds the key or is empty
		logic found;    // the released key sits in this slot or an earlier one
	} chain_t;

	// Maps an ASCII byte to its keycode; KEY_NONE when the byte is not mapped.
	function automatic key_t map_char(input logic [7:0] ch);
		logic [7:0] offs;
		offs = ch - CHAR_ONE;
		if (ch >= CHAR_ONE && ch <= CHAR_NINE) begin
			return KEY_ONE + offs[KEY_W-1:0];
		end else if (ch == CHAR_ZERO) begin
			return KEY_ZERO;
		end else if (ch == CHAR_COMMA) begin
			return KEY_COMMA;
		end else if (ch == CHAR_ESCAPE) begin
			return KEY_ESCAPE;
		end
		return KEY_NONE;
	endfunction

endpackage

[hdl/hsk_slot_cell.sv]
// One slot of the held-key list: holds a keycode and updates it from the
// broadcast command and its neighbors. Depends on hsk_pkg.
module hsk_slot_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  hsk_pkg::cmd_t   cmd,
	input  hsk_pkg::chain_t chain_in,
	output hsk_pkg::chain_t chain_out,
	input  hsk_pkg::key_t   next_slot,
	output hsk_pkg::key_t   slot,
	output logic            wrote
);

	hsk_pkg::key_t slot_q;
	logic          match;
	logic          empty;
	logic          shift;

	assign match = (slot_q == cmd.key);
	assign empty = (slot_q == hsk_pkg::KEY_NONE);

	assign chain_out.blocked = chain_in.blocked | match | empty;
	assign chain_out.found   = chain_in.found | match;

	// A press lands in the first empty slot, unless an earlier slot holds it.
	assign wrote = cmd.valid & (cmd.release_op == hsk_pkg::OP_PRESS)
		& ~chain_in.blocked & empty;
	// A release pulls the later slots down from the matching slot onward.
	assign shift = cmd.valid & (cmd.release_op == hsk_pkg::OP_RELEASE) & chain_out.found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= hsk_pkg::KEY_NONE;
		end else if (wrote) begin
			slot_q <= cmd.key;
		end else if (shift) begin
			slot_q <= next_slot;
		end
	end

	assign slot = slot_q;

endmodule

[hdl/hid_six_key_rollover_report_unit.sv]
// Six-key rollover keyboard report unit: a chain of slot cells behind one
// input register. Depends on hsk_pkg and hsk_slot_cell.
// The input register holds each accepted word while the slot chain applies it
// and done is registered; the report is read while done is high. busy is high
// for the cycle after each accepted word, so the next word waits. Reset clears
// the slots, valid_s1 and done_q; the receiver cannot stall.
module hid_six_key_rollover_report_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       operation,
	input  logic [7:0] character,
	output logic       done,
	output logic [6:0] slot_0,
	output logic [6:0] slot_1,
	output logic [6:0] slot_2,
	output logic [6:0] slot_3,
	output logic [6:0] slot_4,
	output logic [6:0] slot_5
);

	// The first stage maps the character to a keycode. Unmapped characters
	// never reach the cells, so a valid command always carries a nonzero key.
	logic          valid_s1;
	logic          release_s1;
	hsk_pkg::key_t key_s1;
	hsk_pkg::key_t mapped;
	logic          done_q;

	// The next word waits while the cells apply the current one. That keeps
	// the cell registers steady during the done cycle, so the report shows
	// the list exactly as the word that caused it left it.
	assign busy   = valid_s1;
	assign mapped = hsk_pkg::map_char(character);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy & (mapped != hsk_pkg::KEY_NONE);
		end
	end

	always_ff @(posedge clk) begin
		release_s1 <= operation;
		key_s1     <= mapped;
	end

	// The command is broadcast to all cells; the blocked and found flags ripple
	// from the first slot toward the last, and each cell reads its successor's
	// keycode when a release shifts the list down.
	hsk_pkg::cmd_t   cmd;
	hsk_pkg::chain_t chain [hsk_pkg::KEY_SLOTS+1];
	hsk_pkg::key_t   slots [hsk_pkg::KEY_SLOTS+1];
	logic [hsk_pkg::KEY_SLOTS-1:0] wrote;

	assign cmd.valid      = valid_s1;
	assign cmd.release_op = release_s1;
	assign cmd.key        = key_s1;

	assign chain[0].blocked          = 1'b0;
	assign chain[0].found            = 1'b0;
	assign slots[hsk_pkg::KEY_SLOTS] = hsk_pkg::KEY_NONE;

	for (genvar i = 0; i < hsk_pkg::KEY_SLOTS; i++) begin : g_cell
		hsk_slot_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.next_slot (slots[i+1]),
			.slot      (slots[i]),
			.wrote     (wrote[i])
		);
	end

	// A press changes the list when some cell took the key; a release changes
	// it when the key was found anywhere along the chain.
	logic changed;
	assign changed = (release_s1 == hsk_pkg::OP_RELEASE)
		? chain[hsk_pkg::KEY_SLOTS].found : (|wrote);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1 & changed;
		end
	end

	assign done = done_q;

	// The report shows the cell registers directly: during the done cycle they
	// hold the list as left by the word that caused it. Report fields beyond
	// the last slot read as zero.
	hsk_pkg::key_t report [hsk_pkg::OUT_FIELDS];

	for (genvar j = 0; j < hsk_pkg::OUT_FIELDS; j++) begin : g_report
		if (j < hsk_pkg::KEY_SLOTS) begin : g_slot
			assign report[j] = slots[j];
		end else begin : g_empty
			assign report[j] = hsk_pkg::KEY_NONE;
		end
	end

	assign slot_0 = report[0];
	assign slot_1 = report[1];
	assign slot_2 = report[2];
	assign slot_3 = report[3];
	assign slot_4 = report[4];
	assign slot_5 = report[5];

endmodule

[tb/tb.sv]
// Self-checking testbench for the six-key rollover report unit.
// Depends on hsk_pkg and hid_six_key_rollover_report_unit from hdl.
// A directed table is walked first, then random key traffic is checked against a predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hsk_pkg::*;

	// One report: slot j of the output sits in element j.
	typedef logic [OUT_FIELDS-1:0][KEY_W-1:0] report_t;

	// How a row of the directed table is checked.
	typedef enum logic [1:0] {
		ROW_PREDICTED,  // the predictor decides what comes back
		ROW_SILENT,     // the word must not cause a report
		ROW_TYPED       // the report is typed into the table
	} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic       op;
		logic [7:0] ch;
		report_t    rpt;
	} key_row_t;

	// Cycles without any handshake before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 200;
	// Words the random part sends after the directed table.
	localparam int RANDOM_WORDS   = 1325;
	// Cycles to wait after the last report before the run ends.
	localparam int DRAIN_CYCLES   = 6;
	localparam int MAX_MSG_LINES  = 40;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       operation;
	logic [7:0] character;
	logic       done;
	logic [6:0] slot_0, slot_1, slot_2, slot_3, slot_4, slot_5;

	hid_six_key_rollover_report_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.character (character),
		.done      (done),
		.slot_0    (slot_0),
		.slot_1    (slot_1),
		.slot_2    (slot_2),
		.slot_3    (slot_3),
		.slot_4    (slot_4),
		.slot_5    (slot_5)
	);

	// Free-running clock, 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Predictor state: the compact list of held keycodes, slot 0 first.
	key_t    held_list [KEY_SLOTS];
	// Reports the block still owes us, oldest at the front.
	report_t pending_reports [$];
	key_row_t key_rows [$];

	int mismatches;
	int words_sent;
	int reports_seen;
	int full_list_presses;
	int idle_cycles;

	// Every failure goes through here; printing is capped so a broken block
	// cannot flood the log, but every failure is still counted.
	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_MSG_LINES)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// ASCII byte to HID keycode. Digits one to nine form a run, zero comes
	// after nine, and anything outside the handful of keys maps to nothing.
	function automatic key_t keycode_of(input logic [7:0] ch);
		if (ch >= CHAR_ONE && ch <= CHAR_NINE)
			return KEY_ONE + key_t'(ch - CHAR_ONE);
		case (ch)
			CHAR_ZERO:   return KEY_ZERO;
			CHAR_COMMA:  return KEY_COMMA;
			CHAR_ESCAPE: return KEY_ESCAPE;
			default:     return KEY_NONE;
		endcase
	endfunction

	// Applies one key word to the held list. Returns 1 and the new report
	// when the list changed; a press of a held key, a press into a full list,
	// a release of a key that is not held and an unmapped byte change nothing.
	function automatic bit update_held_list(input logic op, input logic [7:0] ch,
			output report_t rpt);
		key_t key;
		bit   changed;
		key     = keycode_of(ch);
		changed = 1'b0;
		rpt     = '0;
		if (key == KEY_NONE)
			return 1'b0;
		if (op == OP_PRESS) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				if (held_list[i] == key)
					break;
				if (held_list[i] == KEY_NONE) begin
					held_list[i] = key;
					changed = 1'b1;
					break;
				end
			end
		end else begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				if (held_list[i] == key) begin
					// Close the gap so the list stays compact.
					for (int j = i; j < KEY_SLOTS - 1; j++)
						held_list[j] = held_list[j + 1];
					held_list[KEY_SLOTS - 1] = KEY_NONE;
					changed = 1'b1;
					break;
				end
			end
		end
		// Only the first OUT_FIELDS slots are visible; missing ones read as zero.
		for (int j = 0; j < OUT_FIELDS; j++)
			rpt[j] = (j < KEY_SLOTS) ? held_list[j] : KEY_NONE;
		return changed;
	endfunction

	// Presents one word and holds it until the block takes it. On return we
	// sit right after the accepting edge, with start still high.
	task automatic send_word(input logic op, input logic [7:0] ch,
			output bit produced, output report_t rpt);
		start     <= 1'b1;
		operation <= op;
		character <= ch;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		words_sent++;
		if (op == OP_PRESS && keycode_of(ch) != KEY_NONE
				&& held_list[KEY_SLOTS - 1] != KEY_NONE)
			full_list_presses++;
		produced = update_held_list(op, ch, rpt);
	endtask

	// With the given odds in percent, drops start for a short random gap so
	// that idle cycles land before, during and after a word in flight.
	task automatic sender_gap(input int pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic add_row(input row_kind_t kind, input logic op, input logic [7:0] ch,
			input key_t s0 = KEY_NONE, input key_t s1 = KEY_NONE,
			input key_t s2 = KEY_NONE, input key_t s3 = KEY_NONE,
			input key_t s4 = KEY_NONE, input key_t s5 = KEY_NONE);
		key_row_t row;
		row.kind = kind;
		row.op   = op;
		row.ch   = ch;
		row.rpt  = {s5, s4, s3, s2, s1, s0};
		key_rows.push_back(row);
	endtask

	// Result side: done marks a report for exactly one cycle, sampled at the
	// edge that ends it. Each report is compared slot by slot with the oldest
	// expectation.
	always @(posedge clk) begin
		report_t got;
		report_t want;
		if (arst_n && done === 1'b1) begin
			got = {slot_5, slot_4, slot_3, slot_2, slot_1, slot_0};
			reports_seen++;
			if (pending_reports.size() == 0) begin
				report_mismatch($sformatf("report %0h with nothing expected", got));
			end else begin
				want = pending_reports.pop_front();
				for (int j = 0; j < OUT_FIELDS; j++)
					if (got[j] !== want[j])
						report_mismatch($sformatf("slot_%0d is %0h, expected %0h",
							j, got[j], want[j]));
			end
		end
	end

	// Watchdog: any accepted word or report resets the count of quiet cycles.
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		report_t    rpt;
		bit         produced;
		key_row_t   row;
		int         made;
		int         idle_pct;
		int         press_pct;
		logic       op;
		logic [7:0] ch;
		logic [7:0] mapped_chars [11];

		words_sent        = 0;
		full_list_presses = 0;
		foreach (held_list[i])
			held_list[i] = KEY_NONE;
		mapped_chars = '{8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
			8'h37, 8'h38, 8'h39, CHAR_COMMA};

		arst_n    <= 1'b0;
		start     <= 1'b0;
		operation <= OP_PRESS;
		character <= 8'h00;

		// Directed table. It fills the list with every mapped key class, hits
		// each case that leaves the list alone, then empties it from the
		// middle so the shifting shows. Keycodes: '9' is 26h, '5' is 22h.
		add_row(ROW_TYPED,  OP_PRESS,   CHAR_ONE,   KEY_ONE);
		add_row(ROW_SILENT, OP_PRESS,   CHAR_ONE);
		add_row(ROW_TYPED,  OP_PRESS,   CHAR_NINE,  KEY_ONE, 7'h26);
		add_row(ROW_TYPED,  OP_PRESS,   CHAR_ZERO,  KEY_ONE, 7'h26, KEY_ZERO);
		add_row(ROW_TYPED,  OP_PRESS,   CHAR_COMMA, KEY_ONE, 7'h26, KEY_ZERO, KEY_COMMA);
		add_row(ROW_TYPED,  OP_PRESS,   CHAR_ESCAPE,
			KEY_ONE, 7'h26, KEY_ZERO, KEY_COMMA, KEY_ESCAPE);
		add_row(ROW_TYPED,  OP_PRESS,   8'h35,
			KEY_ONE, 7'h26, KEY_ZERO, KEY_COMMA, KEY_ESCAPE, 7'h22);
		// The list is full now, so a new key is dropped.
		add_row(ROW_SILENT, OP_PRESS,   8'h37);
		add_row(ROW_SILENT, OP_PRESS,   8'h41);
		add_row(ROW_SILENT, OP_RELEASE, 8'h41);
		add_row(ROW_SILENT, OP_PRESS,   8'hFF);
		add_row(ROW_SILENT, OP_RELEASE, 8'h00);
		add_row(ROW_TYPED,  OP_RELEASE, CHAR_NINE,
			KEY_ONE, KEY_ZERO, KEY_COMMA, KEY_ESCAPE, 7'h22);
		add_row(ROW_SILENT, OP_RELEASE, 8'h32);
		add_row(ROW_TYPED,  OP_RELEASE, CHAR_ONE,  KEY_ZERO, KEY_COMMA, KEY_ESCAPE, 7'h22);
		add_row(ROW_TYPED,  OP_RELEASE, CHAR_ESCAPE, KEY_ZERO, KEY_COMMA, 7'h22);
		add_row(ROW_PREDICTED, OP_PRESS, 8'h38);
		add_row(ROW_PREDICTED, OP_RELEASE, 8'h35);
		add_row(ROW_PREDICTED, OP_RELEASE, CHAR_COMMA);
		add_row(ROW_PREDICTED, OP_RELEASE, 8'h38);
		add_row(ROW_TYPED,  OP_RELEASE, CHAR_ZERO);
		add_row(ROW_SILENT, OP_RELEASE, CHAR_ZERO);
		// Neighbors of the mapped characters must stay unmapped.
		add_row(ROW_SILENT, OP_PRESS,   8'h2F);
		add_row(ROW_SILENT, OP_PRESS,   8'h3A);
		add_row(ROW_SILENT, OP_PRESS,   8'hDE);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (key_rows[r]) begin
			row = key_rows[r];
			send_word(row.op, row.ch, produced, rpt);
			case (row.kind)
				ROW_PREDICTED: if (produced) pending_reports.push_back(rpt);
				ROW_TYPED:     pending_reports.push_back(row.rpt);
				default:       ;
			endcase
			sender_gap(25);
		end

		// Random part. Most words carry a mapped key so the list keeps filling
		// and draining; the rest are arbitrary bytes. The press odds drift in
		// bursts so both full-list and empty-list stretches occur. Idling goes
		// from light to heavy to none across the three thirds of the words.
		made      = 0;
		press_pct = 60;
		while (made < RANDOM_WORDS) begin
			if (made < RANDOM_WORDS / 3)
				idle_pct = 38;
			else if (made < 2 * RANDOM_WORDS / 3)
				idle_pct = 63;
			else
				idle_pct = 0;
			if ($urandom_range(39) == 0)
				press_pct = $urandom_range(30, 85);
			op = ($urandom_range(99) < press_pct) ? OP_PRESS : OP_RELEASE;
			if ($urandom_range(99) < 80)
				ch = mapped_chars[$urandom_range(10)];
			else if ($urandom_range(9) == 0)
				ch = CHAR_ESCAPE;
			else
				ch = 8'($urandom_range(255));
			send_word(op, ch, produced, rpt);
			if (produced)
				pending_reports.push_back(rpt);
			made++;
			sender_gap(idle_pct);
		end
		start <= 1'b0;

		// Drain: the watchdog bounds this wait if a report never shows up.
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d key words, compared %0d reports.", words_sent, reports_seen);
		$display("%0d presses arrived while the list was full.", full_list_presses);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[hid_six_key_rollover_report_unit.f]
hdl/hsk_pkg.sv
hdl/hsk_slot_cell.sv
hdl/hid_six_key_rollover_report_unit.sv
tb/tb.sv
